// File: design/isort_pkg.sv
// Package for the insertion sorter: shared widths, default depth and the
// control struct that the top level hands to every cell of the chain.
// No dependencies.
package isort_pkg;

    localparam int DEFAULT_DEPTH = 32;
    localparam int VALUE_W       = 32;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic ins;       // insert the broadcast value this cycle
        logic shift_dn;  // move every entry one place toward cell 0
    } t_cell_ctl;

endpackage

// File: design/isort_cell.sv
// One cell of the insertion chain: holds one list entry and decides from
// its lower neighbor's compare result whether to take the neighbor's entry,
// the new value, or to keep its own; a shift takes the upper entry. Depends on isort_pkg.
module isort_cell
    import isort_pkg::*;
(
    input  logic                       i_clk,
    input  t_cell_ctl                  i_ctl,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       i_occupied,
    input  logic                       i_at_tail,
    input  logic signed [VALUE_W-1:0]  i_lower_val,
    input  logic                       i_lower_gt,
    input  logic signed [VALUE_W-1:0]  i_upper_val,
    output logic signed [VALUE_W-1:0]  o_val,
    output logic                       o_gt
);

    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;

    // Only strictly greater entries move up, which keeps the sort stable.
    assign o_gt  = i_occupied && (r_val > i_value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.shift_dn) begin
            n_val = i_upper_val;
        end else if (i_ctl.ins) begin
            if (i_lower_gt) begin
                n_val = i_lower_val;
            end else if (o_gt || i_at_tail) begin
                n_val = i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: design/insertion_sorter.sv
// Insertion sorter: stable ascending sort of one list at a time in a chain of DEPTH cells.
// An item is inserted at the edge that accepts it; after the final transfer the state
// register enters the drain, and the output register then shows one result per cycle.
// Throughput: one item per cycle while a list is collected; busy is high after the final
// transfer while the list drains; the receiver cannot stall the results.
// Reset (i_rst_n low, synchronous) empties the store and clears the overflow flag and strobe.
module insertion_sorter
    import isort_pkg::*;
#(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       i_final_item,
    output logic                       o_strobe,
    output logic signed [VALUE_W-1:0]  o_sorted_value,
    output logic                       o_end_of_list,
    output logic                       o_overflowed
);

    // The fill count must be able to hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic {
        ST_IDLE,
        ST_DRAIN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovf;
    logic             n_ovf;

    logic                      accept;
    logic                      full;
    t_cell_ctl                 ctl;
    logic signed [VALUE_W-1:0] cell_val [DEPTH];
    logic                      cell_gt  [DEPTH];

    // The block is held busy while reset is applied so that no transfer is
    // counted during reset, and while a sorted list drains out of the chain.
    assign busy   = (r_state == ST_DRAIN) || !i_rst_n;
    assign accept = start && !busy;
    assign full   = (r_count == CNT_FULL);

    // A new value is inserted only while the store has room; once full, it
    // is dropped and the list is marked as overflowed.
    assign ctl.ins      = accept && !full;
    assign ctl.shift_dn = (r_state == ST_DRAIN);

    // The chain: every cell sees the broadcast value and its lower neighbor's
    // entry and compare result. Greater entries form a suffix of the held
    // list, so each cell above the insertion point takes its lower
    // neighbor's entry and the first greater cell (or the tail) takes the
    // new value. While draining, entries move down one place per cycle and
    // cell 0 feeds the output.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [VALUE_W-1:0] lower_val;
        logic                      lower_gt;
        logic signed [VALUE_W-1:0] upper_val;

        if (k == 0) begin : g_first
            assign lower_val = cell_val[0];
            assign lower_gt  = 1'b0;
        end else begin : g_mid
            assign lower_val = cell_val[k-1];
            assign lower_gt  = cell_gt[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign upper_val = cell_val[k];
        end else begin : g_below
            assign upper_val = cell_val[k+1];
        end

        isort_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_value     (i_value),
            .i_occupied  (CNT_W'(k) < r_count),
            .i_at_tail   (CNT_W'(k) == r_count),
            .i_lower_val (lower_val),
            .i_lower_gt  (lower_gt),
            .i_upper_val (upper_val),
            .o_val       (cell_val[k]),
            .o_gt        (cell_gt[k])
        );
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_ONE;
                    end
                    if (i_final_item) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // One held entry leaves per cycle; the last one ends the list.
                n_count = r_count - CNT_ONE;
                if (r_count == CNT_ONE) begin
                    n_state = ST_IDLE;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_ovf         <= 1'b0;
            o_strobe      <= 1'b0;
            o_end_of_list <= 1'b0;
            o_overflowed  <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_ovf         <= n_ovf;
            o_strobe      <= (r_state == ST_DRAIN);
            o_end_of_list <= (r_state == ST_DRAIN) && (r_count == CNT_ONE);
            o_overflowed  <= (r_state == ST_DRAIN) && r_ovf;
        end
    end

    // The result value needs no reset; it is only meaningful with the strobe.
    always_ff @(posedge i_clk) begin
        o_sorted_value <= cell_val[0];
    end

endmodule

// File: design/isort_chk.sv
// Port-level checker for the insertion sorter, bound to the top level.
// Depends on isort_pkg and on the insertion_sorter ports.
module isort_chk
    import isort_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       i_final_item,
    input  logic                       o_strobe,
    input  logic signed [VALUE_W-1:0]  o_sorted_value,
    input  logic                       o_end_of_list,
    input  logic                       o_overflowed
);

    // A final transfer starts the drain of the list.
    a_final_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_final_item |=> busy)
        else $error("final transfer did not start the drain");

    // Results of one list come in an unbroken, ascending run up to the end marker.
    a_run_unbroken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_end_of_list |=>
            o_strobe && (o_sorted_value >= $past(o_sorted_value)))
        else $error("result run broken or out of order before end of list");

    // The block is free again as soon as the last result is shown.
    a_free_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_end_of_list |-> !busy)
        else $error("still busy on the last result");

    // The overflow flag is the same on every result of one list.
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_end_of_list |=> $stable(o_overflowed))
        else $error("overflow flag changed within a list");

    // Results appear only while the list drains or right as it ends.
    a_strobe_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_end_of_list |-> busy)
        else $error("result shown outside a drain");

endmodule

bind insertion_sorter isort_chk u_isort_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_final_item   (i_final_item),
    .o_strobe       (o_strobe),
    .o_sorted_value (o_sorted_value),
    .o_end_of_list  (o_end_of_list),
    .o_overflowed   (o_overflowed)
);

// File: tb/sv/insertion_sorter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for insertion_sorter: random lists are sorted by the block and
// compared, result by result, with a behavioral sort kept inside the bench.
// Depends on isort_pkg and the insertion_sorter RTL.
module insertion_sorter_tb;
    import isort_pkg::*;

    localparam int DEPTH      = DEFAULT_DEPTH;
    localparam int CYCLE_CAP  = 100000;
    localparam int TAIL_WAIT  = DEPTH + 8;

    // One list element as the sender hands it to the block.
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      final_item;
    } t_list_elem;

    // One sorted result as the block should emit it.
    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      end_of_list;
        logic                      overflowed;
    } t_sorted_elem;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      start          = 1'b0;
    logic signed [VALUE_W-1:0] i_value        = '0;
    logic                      i_final_item   = 1'b0;
    logic                      busy;
    logic                      o_strobe;
    logic signed [VALUE_W-1:0] o_sorted_value;
    logic                      o_end_of_list;
    logic                      o_overflowed;

    // Elements waiting to be sent, and sorted results the block still owes us.
    t_list_elem   send_q[$];
    t_sorted_elem owed_sorted_q[$];

    // Shadow of the block's store: the held elements in ascending order.
    logic signed [VALUE_W-1:0] held_vals [DEPTH];
    int                        held_count = 0;
    logic                      dropped    = 1'b0;

    // Sender pacing: a burst of transfers, then a gap with start low.
    int burst_left = 1;
    int gap_left   = 0;

    int error_count = 0;
    int cycle_count = 0;
    int rand_items  = 0;

    insertion_sorter #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_final_item   (i_final_item),
        .o_strobe       (o_strobe),
        .o_sorted_value (o_sorted_value),
        .o_end_of_list  (o_end_of_list),
        .o_overflowed   (o_overflowed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Insert one accepted element into the shadow store. Only a strictly greater
    // neighbor moves up, so equal values keep their arrival order. Once the store
    // is full, further elements are dropped and the list is marked as overflowed.
    // A final element releases the whole held list as owed results.
    task automatic sort_insert(input logic signed [VALUE_W-1:0] v, input logic last);
        int pos;
        int k;
        if (held_count < DEPTH) begin
            pos = held_count;
            while (pos > 0 && held_vals[pos-1] > v) begin
                held_vals[pos] = held_vals[pos-1];
                pos--;
            end
            held_vals[pos] = v;
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (last) begin
            for (k = 0; k < held_count; k++) begin
                owed_sorted_q = {owed_sorted_q,
                                 t_sorted_elem'{value:       held_vals[k],
                                                end_of_list: (k == held_count - 1),
                                                overflowed:  dropped}};
            end
            held_count = 0;
            dropped    = 1'b0;
        end
    endtask

    task automatic push_elem(input logic signed [VALUE_W-1:0] v, input logic last);
        send_q = {send_q, t_list_elem'{value: v, final_item: last}};
    endtask

    // Random element: full-range values half of the time, with a share of small
    // values so that duplicates are common, and the extremes now and then.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1, 2: v = $urandom;
            3, 4:    v = $signed($urandom_range(0, 16)) - 8;
            default: begin
                case ($urandom_range(0, 3))
                    0:       v = {1'b1, {(VALUE_W-1){1'b0}}};
                    1:       v = {1'b0, {(VALUE_W-1){1'b1}}};
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Queue a list of len random elements; the last one carries the final flag.
    task automatic add_random_list(input int len);
        int k;
        for (k = 0; k < len; k++) begin
            push_elem(pick_value(), k == len - 1);
        end
        rand_items += len;
    endtask

    // Driver. A transfer happens at an edge where start is high and busy is low;
    // the accepted element goes into the shadow store right there. While busy
    // holds a request off, start and the payload simply stay where they are.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sort_insert(i_value, i_final_item);
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (send_q.size() > 0) begin
                    i_value      <= send_q[0].value;
                    i_final_item <= send_q[0].final_item;
                    send_q.pop_front();
                    start <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        // New burst length and gap; about a quarter of the
                        // bursts run straight into the next one.
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor. The receiver cannot stall the block, so every strobed cycle is a
    // transfer and is checked against the oldest owed result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (owed_sorted_q.size() == 0) begin
                $error("unexpected result: sorted_value %0d with nothing owed", o_sorted_value);
                error_count++;
            end else begin
                if (o_sorted_value !== owed_sorted_q[0].value) begin
                    $error("sorted_value: expected %0d, got %0d",
                           owed_sorted_q[0].value, o_sorted_value);
                    error_count++;
                end
                if (o_end_of_list !== owed_sorted_q[0].end_of_list) begin
                    $error("end_of_list: expected %0b, got %0b",
                           owed_sorted_q[0].end_of_list, o_end_of_list);
                    error_count++;
                end
                if (o_overflowed !== owed_sorted_q[0].overflowed) begin
                    $error("overflowed: expected %0b, got %0b",
                           owed_sorted_q[0].overflowed, o_overflowed);
                    error_count++;
                end
                owed_sorted_q.pop_front();
            end
        end
    end

    // Watchdog: the slowest correct run is far below this cap.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("insertion_sorter_tb: done, errors");
            $finish;
        end
    end

    initial begin
        // Directed lists. Single-element lists at both extremes.
        push_elem({1'b0, {(VALUE_W-1){1'b1}}}, 1'b1);
        push_elem({1'b1, {(VALUE_W-1){1'b0}}}, 1'b1);
        // Extremes, zero and the values next to it, with repeated extremes.
        push_elem('0, 1'b0);
        push_elem({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
        push_elem({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
        push_elem('1, 1'b0);
        push_elem(1, 1'b0);
        push_elem({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
        push_elem({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
        push_elem('0, 1'b1);
        // Equal values interleaved, where stability matters.
        push_elem(7, 1'b0);
        push_elem(7, 1'b0);
        push_elem(-3, 1'b0);
        push_elem(7, 1'b0);
        push_elem(-3, 1'b1);
        // Reverse order, then already sorted.
        push_elem(4, 1'b0);
        push_elem(3, 1'b0);
        push_elem(2, 1'b0);
        push_elem(1, 1'b1);
        push_elem(1, 1'b0);
        push_elem(2, 1'b0);
        push_elem(3, 1'b1);

        // Random lists. A full store without overflow, then one element too many,
        // so that the final element itself is the one dropped. After that, mostly
        // short lists with an occasional long one around the capacity.
        add_random_list(DEPTH);
        add_random_list(DEPTH + 1);
        while (rand_items < 80) begin
            if ($urandom_range(0, 9) == 0) begin
                add_random_list($urandom_range(DEPTH - 2, DEPTH + 6));
            end else begin
                add_random_list($urandom_range(1, 10));
            end
        end

        burst_left = $urandom_range(1, 20);
        gap_left   = $urandom_range(0, 4);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every element has been transferred and every owed result
        // has come back; sampled mid-cycle, away from the clock edge.
        do begin
            @(negedge i_clk);
        end while (send_q.size() > 0 || start || owed_sorted_q.size() > 0);

        // Let a stray result from the drain logic show up, if there is one.
        repeat (TAIL_WAIT) @(posedge i_clk);
        @(negedge i_clk);

        if (error_count == 0) begin
            $display("insertion_sorter_tb: done, clean");
        end else begin
            $display("insertion_sorter_tb: done, errors");
        end
        $finish;
    end

endmodule
